### design/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg: shared constants and types for the combined LCG shuffle generator
// Moduli, multipliers, folding constants, slot thresholds, sequencer codes.
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 8);
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned FRAC_W = 32;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = VAL_W + MUL_W;

  localparam logic [31:0] MOD_A = 32'd2147483563;
  localparam logic [31:0] MOD_B = 32'd2147483399;
  localparam logic [MUL_W-1:0] MUL_A = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_B = 16'd40692;
  localparam logic [31:0] SPAN = MOD_A - 32'd1;

  // 2^31 is congruent to these small values, so a product folds in one add
  localparam longint unsigned TWO31 = 64'd1 << 31;
  localparam logic [7:0] FOLD_A = 8'(TWO31 - 64'(MOD_A));
  localparam logic [7:0] FOLD_B = 8'(TWO31 - 64'(MOD_B));

  // 2^32 = 2*MOD_A + 2*FOLD_A
  localparam logic [MUL_W-1:0] FRAC_MUL = MUL_W'(2 * (TWO31 - 64'(MOD_A)));
  localparam logic [FRAC_W-1:0] FRAC_CLAMP = 32'd4294966780;

  localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

  localparam logic [31:0] SLOT_DIV = 32'd1 + SPAN / TABLE_ENTRIES;
  localparam logic [MUL_W-1:0] SLOT_RECIP = MUL_W'((64'd1 << 32) / 64'(SLOT_DIV));

  typedef logic [31:0] thr_tab_t [TABLE_ENTRIES];

  function automatic thr_tab_t build_slot_thr();
    thr_tab_t tab;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tab[k] = 32'(longint'(k) * longint'(SLOT_DIV));
    end
    return tab;
  endfunction

  // lower bound of each slot's range of previous outputs
  localparam thr_tab_t SLOT_THR = build_slot_thr();

  typedef enum logic [1:0] {
    OP_MOD_A,
    OP_MOD_B,
    OP_FRAC,
    OP_SLOT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_MUL,
    S_INIT_RED,
    S_SLOT,
    S_STEP_A,
    S_STEP_B,
    S_MIX,
    S_COMBINE,
    S_FRAC,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [VAL_W-1:0] operand;
  } mu_req_t;

endpackage

### design/clsr_if.sv
// ----------------------------------------------------------------------------
// clsr_if: valid/ready channels of the combined LCG shuffle generator
// Draw request, draw result and seed write channels.
// ----------------------------------------------------------------------------
interface clsr_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface clsr_draw_if;
  logic                          valid;
  logic                          ready;
  logic [clsr_pkg::VAL_W-1:0]    draw_value;
  logic [clsr_pkg::FRAC_W-1:0]   draw_fraction;

  modport source (output valid, output draw_value, output draw_fraction, input ready);
  modport sink   (input valid, input draw_value, input draw_fraction, output ready);
endinterface

interface clsr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [clsr_pkg::VAL_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

### design/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng: combined LCG random generator with shuffle table
// Sequence: slot, both generator steps, mix, combine and fraction states lead
//   to a registered result, after 40 warm-up steps on the first request or a
//   restart. A request is taken only in idle, as the sequencer shares a single
//   multiply/fold unit across slot, both generator steps and the fraction.
// Reset: the first generator, flags and handshakes clear and the second loads
//   SECOND_RESET; the table is not cleared and is filled by the initialization
//   that the first request always triggers.
module combined_lcg_shuffle_rng (
  input  logic        clk_i,
  input  logic        rst_ni,
  clsr_cfg_if.sink    cfg_i,
  clsr_req_if.sink    req_i,
  clsr_draw_if.source draw_o
);
  import clsr_pkg::*;

  state_e            state_q, state_d;
  logic [VAL_W-1:0]  seed_q;
  logic [VAL_W-1:0]  seed_eff;
  logic [VAL_W-1:0]  first_q, first_d;
  logic [VAL_W-1:0]  second_q, second_d;
  logic [VAL_W-1:0]  last_q, last_d;
  logic              init_q, init_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  logic [FRAC_W-1:0] out_frac_q, out_frac_d;
  logic              req_ready;

  mu_req_t           mu_req;
  logic [FRAC_W-1:0] mu_res;

  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  logic [VAL_W-1:0]  tbl_wdata;
  logic              tbl_re;
  logic [VAL_W-1:0]  tbl_rdata;

  logic              mix_wrap;
  logic [31:0]       mix;

  // Shared multiply/fold unit: result appears the cycle after issue.
  clsr_arith_unit u_arith (
    .clk_i (clk_i),
    .req_i (mu_req),
    .res_o (mu_res)
  );

  clsr_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (slot_q),
    .rdata_o (tbl_rdata)
  );

  // Seed of zero starts both generators at one.
  assign seed_eff = (seed_q == '0) ? VAL_W'(1) : seed_q;

  // Old slot value minus second generator, wrapped into 1..SPAN.
  assign mix_wrap = (tbl_rdata <= second_q);
  assign mix      = {1'b0, tbl_rdata} + (mix_wrap ? SPAN : 32'd0) - {1'b0, second_q};

  // Seed register: take every write request.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_i.valid) begin
      seed_q <= cfg_i.seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= '0;
      second_q    <= SECOND_RESET;
      last_q      <= '0;
      init_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      last_q      <= last_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    out_value_q <= out_value_d;
    out_frac_q  <= out_frac_d;
  end

  // Sequencer: at most one operation per state through the shared unit.
  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    second_d    = second_q;
    last_d      = last_q;
    init_d      = init_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_frac_d  = out_frac_q;
    req_ready   = 1'b0;

    mu_req.op      = OP_MOD_A;
    mu_req.operand = first_q;

    tbl_we    = 1'b0;
    tbl_waddr = slot_q;
    tbl_wdata = first_q;
    tbl_re    = 1'b0;

    // drop the held result once the sink takes it
    if (out_valid_q && draw_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          if (!init_q || req_i.restart) begin
            first_d  = seed_eff;
            second_d = seed_eff;
            cnt_d    = CNT_W'(TABLE_ENTRIES + 7);
            state_d  = S_INIT_MUL;
          end else begin
            state_d = S_SLOT;
          end
        end
      end

      // Warm-up: step the first generator, keep the last entries in the table.
      S_INIT_MUL: begin
        mu_req.op      = OP_MOD_A;
        mu_req.operand = first_q;
        state_d        = S_INIT_RED;
      end

      S_INIT_RED: begin
        first_d = mu_res[VAL_W-1:0];
        if (cnt_q < CNT_W'(TABLE_ENTRIES)) begin
          tbl_we    = 1'b1;
          tbl_waddr = cnt_q[IDX_W-1:0];
          tbl_wdata = mu_res[VAL_W-1:0];
        end
        if (cnt_q == '0) begin
          last_d  = mu_res[VAL_W-1:0];
          init_d  = 1'b1;
          state_d = S_SLOT;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_INIT_MUL;
        end
      end

      // Draw: slot from previous output, advance both generators.
      S_SLOT: begin
        mu_req.op      = OP_SLOT;
        mu_req.operand = last_q;
        state_d        = S_STEP_A;
      end

      S_STEP_A: begin
        slot_d         = mu_res[IDX_W-1:0];
        mu_req.op      = OP_MOD_A;
        mu_req.operand = first_q;
        state_d        = S_STEP_B;
      end

      S_STEP_B: begin
        first_d        = mu_res[VAL_W-1:0];
        mu_req.op      = OP_MOD_B;
        mu_req.operand = second_q;
        tbl_re         = 1'b1;
        state_d        = S_MIX;
      end

      // Old slot value is captured; replace it with the new first generator.
      S_MIX: begin
        second_d  = mu_res[VAL_W-1:0];
        tbl_we    = 1'b1;
        tbl_waddr = slot_q;
        tbl_wdata = first_q;
        state_d   = S_COMBINE;
      end

      S_COMBINE: begin
        last_d  = mix[VAL_W-1:0];
        state_d = S_FRAC;
      end

      S_FRAC: begin
        mu_req.op      = OP_FRAC;
        mu_req.operand = last_q;
        state_d        = S_OUT;
      end

      // Keep reissuing the fraction so a stalled output still sees it.
      S_OUT: begin
        mu_req.op      = OP_FRAC;
        mu_req.operand = last_q;
        if (!out_valid_q || draw_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = last_q;
          out_frac_d  = mu_res;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_i.ready          = req_ready;
  assign draw_o.valid         = out_valid_q;
  assign draw_o.draw_value    = out_value_q;
  assign draw_o.draw_fraction = out_frac_q;

endmodule

### design/clsr_arith_unit.sv
// ----------------------------------------------------------------------------
// clsr_arith_unit: shared constant multiplier with folding reduction
// Stage one multiplies, stage two reduces to a residue, fraction or slot.
// ----------------------------------------------------------------------------
module clsr_arith_unit (
  input  logic                        clk_i,
  input  clsr_pkg::mu_req_t           req_i,
  output logic [clsr_pkg::FRAC_W-1:0] res_o
);
  import clsr_pkg::*;

  localparam int unsigned HI_W = PROD_W - VAL_W;
  localparam int unsigned Q_W  = PROD_W - 32;

  logic [MUL_W-1:0]  coef;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  opnd_q;
  op_e               op_q;

  logic [HI_W-1:0]   hi;
  logic [VAL_W-1:0]  lo;
  logic [31:0]       fold_a;
  logic [31:0]       fold_b;
  logic              ge_a;
  logic              ge_b;
  logic [31:0]       mod_a;
  logic [31:0]       mod_b;
  logic [32:0]       frac_sum;
  logic [FRAC_W-1:0] frac;
  logic [Q_W-1:0]    q0;
  logic [IDX_W-1:0]  q_inc;
  logic [IDX_W-1:0]  slot;

  always_comb begin
    case (req_i.op)
      OP_MOD_A: coef = MUL_A;
      OP_MOD_B: coef = MUL_B;
      OP_FRAC:  coef = FRAC_MUL;
      OP_SLOT:  coef = SLOT_RECIP;
      default:  coef = MUL_A;
    endcase
  end

  assign prod_d = PROD_W'(req_i.operand) * PROD_W'(coef);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    opnd_q <= req_i.operand;
    op_q   <= req_i.op;
  end

  // fold the bits above 2^31 back in, then one conditional subtract
  assign hi     = prod_q[PROD_W-1:VAL_W];
  assign lo     = prod_q[VAL_W-1:0];
  assign fold_a = 32'(hi) * 32'(FOLD_A) + 32'(lo);
  assign fold_b = 32'(hi) * 32'(FOLD_B) + 32'(lo);
  assign ge_a   = (fold_a >= MOD_A);
  assign ge_b   = (fold_b >= MOD_B);
  assign mod_a  = ge_a ? (fold_a - MOD_A) : fold_a;
  assign mod_b  = ge_b ? (fold_b - MOD_B) : fold_b;

  // floor(v * 2^32 / MOD_A) = 2v + floor(2*FOLD_A*v / MOD_A)
  assign frac_sum = {1'b0, opnd_q, 1'b0} + 33'(hi) + 33'(ge_a);
  assign frac     = (frac_sum > 33'(FRAC_CLAMP)) ? FRAC_CLAMP : frac_sum[FRAC_W-1:0];

  // reciprocal estimate is low by at most one; fix up against the threshold
  assign q0    = prod_q[PROD_W-1:32];
  assign q_inc = IDX_W'(q0 + Q_W'(1));

  always_comb begin
    if (q0 >= Q_W'(TABLE_ENTRIES - 1)) begin
      slot = IDX_W'(TABLE_ENTRIES - 1);
    end else if ({1'b0, opnd_q} >= SLOT_THR[q_inc]) begin
      slot = q_inc;
    end else begin
      slot = IDX_W'(q0);
    end
  end

  always_comb begin
    case (op_q)
      OP_MOD_A: res_o = {1'b0, mod_a[VAL_W-1:0]};
      OP_MOD_B: res_o = {1'b0, mod_b[VAL_W-1:0]};
      OP_FRAC:  res_o = frac;
      OP_SLOT:  res_o = FRAC_W'(slot);
      default:  res_o = '0;
    endcase
  end

endmodule

### design/clsr_table.sv
// ----------------------------------------------------------------------------
// clsr_table: shuffle table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module clsr_table (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [clsr_pkg::IDX_W-1:0] waddr_i,
  input  logic [clsr_pkg::VAL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [clsr_pkg::IDX_W-1:0] raddr_i,
  output logic [clsr_pkg::VAL_W-1:0] rdata_o
);
  import clsr_pkg::*;

  logic [VAL_W-1:0] mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/clsr_checker.sv
// ----------------------------------------------------------------------------
// clsr_checker: port-level checks for the combined LCG shuffle generator
// Result ranges, busy after a request, and result hold under stall.
// ----------------------------------------------------------------------------
module clsr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        draw_valid_i,
  input logic                        draw_ready_i,
  input logic [clsr_pkg::VAL_W-1:0]  draw_value_i,
  input logic [clsr_pkg::FRAC_W-1:0] draw_fraction_i
);
  import clsr_pkg::*;

  // hold the result while the sink stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_valid_i && !draw_ready_i |=>
      draw_valid_i && $stable(draw_value_i) && $stable(draw_fraction_i))
  else $error("draw result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_valid_i |-> (draw_value_i != '0) && (32'(draw_value_i) <= SPAN))
  else $error("draw value out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_valid_i |-> (draw_fraction_i <= FRAC_CLAMP))
  else $error("draw fraction above clamp");

  // a taken request keeps the sequencer busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
  else $error("request taken while busy");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .draw_valid_i    (draw_o.valid),
  .draw_ready_i    (draw_o.ready),
  .draw_value_i    (draw_o.draw_value),
  .draw_fraction_i (draw_o.draw_fraction)
);

### test/rng_draw_checker.sv
// ----------------------------------------------------------------------------
// rng_draw_checker: draw predictor and comparator for the shuffle generator
// Follows seed writes and draw requests on the bus, models both generators
// and the shuffle table, and compares every returned draw with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rng_draw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  clsr_cfg_if         cfg_mon,
  clsr_req_if         req_mon,
  clsr_draw_if        draw_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_draws_o
);

  localparam int unsigned      SLOTS        = 32;
  localparam int unsigned      WARMUP_STEPS = SLOTS + 8;
  localparam longint unsigned  A_MOD        = 64'd2147483563;
  localparam longint unsigned  B_MOD        = 64'd2147483399;
  localparam longint unsigned  A_MUL        = 64'd40014;
  localparam longint unsigned  B_MUL        = 64'd40692;
  localparam longint unsigned  SPAN         = A_MOD - 64'd1;
  localparam longint unsigned  SLOT_DIV     = 64'd1 + SPAN / SLOTS;
  localparam longint unsigned  FRAC_CLAMP   = 64'd4294966780;
  localparam int unsigned      B_RESET      = 123456789;
  localparam int unsigned      MAX_PRINTED  = 40;

  typedef logic [clsr_pkg::VAL_W-1:0] value_t;

  typedef struct packed {
    value_t                       value;
    logic [clsr_pkg::FRAC_W-1:0]  fraction;
  } draw_t;

  value_t seed_q;
  value_t gen_a;
  value_t gen_b;
  value_t prev_draw;
  value_t shuffle [SLOTS];
  logic   table_loaded;
  draw_t  expected_draws [$];

  function automatic value_t advance(input value_t z, input longint unsigned mul,
                                     input longint unsigned modulus);
    return value_t'((mul * 64'(z)) % modulus);
  endfunction

  // Advance the model by one draw; reseed and refill the table first when asked.
  function automatic draw_t predict_draw(input logic restart);
    value_t          start;
    int unsigned     slot;
    longint          diff;
    longint unsigned frac;
    draw_t           d;
    if (!table_loaded || restart) begin
      start = (seed_q == '0) ? value_t'(1) : seed_q;
      gen_a = start;
      gen_b = start;
      for (int n = WARMUP_STEPS - 1; n >= 0; n--) begin
        gen_a = advance(gen_a, A_MUL, A_MOD);
        if (n < SLOTS) shuffle[n] = gen_a;
      end
      prev_draw    = shuffle[0];
      table_loaded = 1'b1;
    end
    gen_a = advance(gen_a, A_MUL, A_MOD);
    gen_b = advance(gen_b, B_MUL, B_MOD);
    slot = int'(64'(prev_draw) / SLOT_DIV);
    if (slot >= SLOTS) slot = SLOTS - 1;
    diff = longint'(64'(shuffle[slot])) - longint'(64'(gen_b));
    shuffle[slot] = gen_a;
    if (diff < 1) diff += longint'(SPAN);
    prev_draw = value_t'(diff);
    frac = (64'(prev_draw) << 32) / A_MOD;
    if (frac > FRAC_CLAMP) frac = FRAC_CLAMP;
    d.value    = prev_draw;
    d.fraction = 32'(frac);
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count_o < MAX_PRINTED) $display("%0t ns: draw mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    if (!rst_ni) begin
      seed_q       = '0;
      gen_a        = '0;
      gen_b        = value_t'(B_RESET);
      prev_draw    = '0;
      table_loaded = 1'b0;
      expected_draws.delete();
      pending_draws_o = 0;
    end else begin
      // check returned draws before queuing this edge's request
      if (draw_mon.valid && draw_mon.ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("draw 0x%08h returned with no request outstanding",
                                    draw_mon.draw_value));
        end else begin
          want = expected_draws.pop_front();
          if (draw_mon.draw_value !== want.value)
            report_mismatch($sformatf("draw_value 0x%08h, predicted 0x%08h",
                                      draw_mon.draw_value, want.value));
          if (draw_mon.draw_fraction !== want.fraction)
            report_mismatch($sformatf("draw_fraction 0x%08h, predicted 0x%08h",
                                      draw_mon.draw_fraction, want.fraction));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) seed_q = cfg_mon.seed;
      if (req_mon.valid && req_mon.ready) expected_draws.push_back(predict_draw(req_mon.restart));
      pending_draws_o = expected_draws.size();
    end
  end

endmodule

### test/tb_combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// tb_combined_lcg_shuffle_rng: stimulus and verdict for the shuffle generator
// Drives seed writes and draw requests with random gaps and receiver stalls,
// including one long receiver hold-off, while rng_draw_checker predicts and
// compares every draw. Directed seeds cover zero, the values that park either
// generator at zero, the top of range and all ones; random phases follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_combined_lcg_shuffle_rng;

  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned RANDOM_PHASES   = 20;
  // long receiver stall, started once this many draws have been taken
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned HOLD_OFF_AFTER  = 60;
  // margin for a stray draw to show after the last one returns
  localparam int unsigned DRAIN_CYCLES    = 16;
  // cycles with no request of any kind before the run is declared hung
  localparam int unsigned STALL_LIMIT     = 2000;

  typedef logic [clsr_pkg::VAL_W-1:0] seed_t;

  localparam seed_t SEED_FIRST_GEN_ZERO  = 31'd2147483563;
  localparam seed_t SEED_SECOND_GEN_ZERO = 31'd2147483399;
  localparam seed_t SEED_TOP_OF_RANGE    = 31'd2147483562;
  localparam seed_t SEED_ALL_ONES        = '1;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_draws;
  int unsigned draws_taken;
  // quiet: no idling on that side for a stretch
  bit          sender_quiet;
  bit          receiver_quiet;

  clsr_cfg_if  seed_bus ();
  clsr_req_if  req_bus ();
  clsr_draw_if draw_bus ();

  combined_lcg_shuffle_rng u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (seed_bus),
    .req_i  (req_bus),
    .draw_o (draw_bus)
  );

  rng_draw_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_mon         (seed_bus),
    .req_mon         (req_bus),
    .draw_mon        (draw_bus),
    .fail_count_o    (fail_count),
    .pending_draws_o (pending_draws)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset, drive every input to a known value, then release reset.
  initial begin : reset_and_defaults
    rst_ni           = 1'b0;
    seed_bus.valid   = 1'b0;
    seed_bus.seed    = '0;
    req_bus.valid    = 1'b0;
    req_bus.restart  = 1'b0;
    draw_bus.ready   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned idle_cycles(input bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one draw request and hold it until the block takes it. Called and
  // returning at a falling edge; valid stays high for a back-to-back request.
  task automatic send_request(input logic restart);
    int unsigned gap;
    gap = idle_cycles(sender_quiet);
    if (gap != 0) begin
      req_bus.valid   <= 1'b0;
      // restart is noise while nothing is offered
      req_bus.restart <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.restart <= restart;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  // Drop the request line, let every outstanding draw come back so the block
  // is idle, then write the seed register.
  task automatic reseed(input seed_t value);
    req_bus.valid <= 1'b0;
    while (pending_draws != 0) @(negedge clk_i);
    seed_bus.valid <= 1'b1;
    seed_bus.seed  <= value;
    do @(posedge clk_i); while (!seed_bus.ready);
    @(negedge clk_i);
    seed_bus.valid <= 1'b0;
  endtask

  // Draw receiver: random stalls, plus one long hold-off so the block fills
  // up and has to push back on the request side.
  initial begin : draw_receiver
    int unsigned gap;
    bit          held_off;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held_off && draws_taken >= HOLD_OFF_AFTER) begin
        draw_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        held_off = 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
        gap = idle_cycles(receiver_quiet);
        if (gap != 0) begin
          draw_bus.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        draw_bus.ready <= 1'b1;
        do @(posedge clk_i); while (!draw_bus.valid);
        draws_taken++;
        @(negedge clk_i);
      end
    end
  end

  // Hang detection: count cycles in which no request moves on any channel.
  initial begin : watchdog
    int unsigned stalled;
    wait (rst_ni === 1'b1);
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (draw_bus.valid && draw_bus.ready) ||
          (seed_bus.valid && seed_bus.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned burst;
    seed_t       value;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    // First draw after reset carries restart; seed is still at its reset
    // value of zero, so both generators start at one.
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // Write zero between draws: the old sequence must carry on until restart.
    reseed('0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);

    // Seed equal to the first modulus parks the first generator at zero.
    reseed(SEED_FIRST_GEN_ZERO);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // Seed equal to the second modulus parks the second generator at zero.
    reseed(SEED_SECOND_GEN_ZERO);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // Out-of-range seed with every bit set, then the largest in-range seed.
    reseed(SEED_ALL_ONES);
    send_request(1'b1);
    send_request(1'b0);
    reseed(SEED_TOP_OF_RANGE);
    send_request(1'b1);
    send_request(1'b0);

    // Back-to-back restarts from the smallest nonzero seed.
    reseed(seed_t'(1));
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);

    // Random phases: a fresh seed, a restart at the head of most phases, and
    // long runs of plain draws with an occasional restart inside.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 15))
        0:       value = '0;
        1:       value = SEED_FIRST_GEN_ZERO;
        2:       value = SEED_SECOND_GEN_ZERO;
        3:       value = SEED_ALL_ONES;
        4:       value = SEED_TOP_OF_RANGE;
        default: value = seed_t'($urandom);
      endcase
      reseed(value);
      sender_quiet = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(60, 140);
      send_request($urandom_range(0, 3) != 0);
      repeat (burst - 1) send_request($urandom_range(0, 39) == 0);
    end

    // Stop offering, drain what is in flight, then give the block time to
    // show any stray draw.
    req_bus.valid <= 1'b0;
    while (pending_draws != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### combined_lcg_shuffle_rng.f
design/clsr_pkg.sv
design/clsr_if.sv
design/clsr_arith_unit.sv
design/clsr_table.sv
design/combined_lcg_shuffle_rng.sv
design/clsr_checker.sv
test/rng_draw_checker.sv
test/tb_combined_lcg_shuffle_rng.sv
